FILE: hdl/sat_pkg.sv
package sat_pkg;

  // Default slot count for the alarm bank
  localparam int unsigned ALARM_SLOTS_DEF = 8;

  // Request opcodes; codes 6 and 7 do nothing and answer ok
  typedef enum logic [2:0] {
    OP_SET_TIME  = 3'd0,
    OP_READ_ELAP = 3'd1,
    OP_ARM_ABS   = 3'd2,
    OP_ARM_DELTA = 3'd3,
    OP_QUERY     = 3'd4,
    OP_CLEAR     = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_INDEX   = 2'd1,
    ST_NOT_RUNNING = 2'd2,
    ST_ZERO_DELTA  = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_DECODE,
    SQ_SET_CMP,
    SQ_SW_RD,
    SQ_SW_CHK,
    SQ_EL_SUB,
    SQ_EL_ADD,
    SQ_ARM_ADD,
    SQ_Q_CHK,
    SQ_EMIT
  } seq_e;

  // Flags of the shared adder; for a subtract, carry means a >= b
  typedef struct packed {
    logic carry;
    logic zero;
  } alu_flags_t;

endpackage

FILE: hdl/sat_alu.sv
module sat_alu (
  input  logic [31:0]         a_i,
  input  logic [31:0]         b_i,
  input  logic                sub_i,
  output logic [31:0]         sum_o,
  output sat_pkg::alu_flags_t flags_o
);
  import sat_pkg::*;

  logic [32:0] sum_w;
  logic [31:0] b_w;

  // Add, or subtract as a + ~b + 1
  assign b_w   = sub_i ? ~b_i : b_i;
  assign sum_w = {1'b0, a_i} + {1'b0, b_w} + {32'd0, sub_i};

  assign sum_o         = sum_w[31:0];
  assign flags_o.carry = sum_w[32];
  assign flags_o.zero  = (sum_w[31:0] == 32'd0);

endmodule

FILE: hdl/seconds_alarm_table.sv
// Channel  Direction  Handshake                  Payload
// in       request    in_valid_i / in_stall_o    opcode, alarm_index, time_value, now_seconds
// out      result     out_valid_o / out_stall_i  status, elapsed_count, slot_armed,
//                                                slot_fired, slot_fire_count
//
// Sequencer around one shared 32-bit adder, one request at a time. Set time moving forward
// on a running clock sweeps every slot (read its due time, then compare and fire); the
// other requests take no sweep. The sequencer returns to idle after the result beat
// is loaded, and only then is the next request taken.
// Reset clears flags, counters and sequencer; due and fire-count memories are not
// cleared, fire counts carry a per-slot valid bit instead.
// A result beat holds in the output register while out_stall_i is high, adding its stall.
module seconds_alarm_table #(
  parameter int unsigned ALARM_SLOTS = sat_pkg::ALARM_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  alarm_index_i,
  input  logic [31:0] time_value_i,
  input  logic [31:0] now_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] elapsed_count_o,
  output logic        slot_armed_o,
  output logic        slot_fired_o,
  output logic [15:0] slot_fire_count_o
);
  import sat_pkg::*;

  localparam int unsigned IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ALARM_SLOTS - 1);

  // Sequencer and timekeeping state
  seq_e                   state_q, state_d;
  logic                   running_q, running_d;
  logic [31:0]            elapsed_q, elapsed_d;
  logic [31:0]            last_q, last_d;
  logic [ALARM_SLOTS-1:0] armed_q, armed_d;
  logic [ALARM_SLOTS-1:0] fired_q, fired_d;
  logic [ALARM_SLOTS-1:0] ftv_q, ftv_d;
  logic [IDX_W-1:0]       k_q, k_d;
  logic                   out_valid_q, out_valid_d;

  // Request and work registers
  logic [2:0]       op_q;
  logic [IDX_W-1:0] idx_q;
  logic             idx_ok_q;
  logic [31:0]      tv_q;
  logic [31:0]      now_q;
  logic [31:0]      diff_q, diff_d;
  logic             gt_q, gt_d;
  logic [IDX_W-1:0] rd_addr_q, rd_addr_d;
  status_e          res_status_q, res_status_d;
  logic [31:0]      res_elapsed_q, res_elapsed_d;
  logic             res_armed_q, res_armed_d;
  logic             res_fired_q, res_fired_d;
  logic [15:0]      res_count_q, res_count_d;
  logic [1:0]       out_status_q;
  logic [31:0]      out_elapsed_q;
  logic             out_armed_q;
  logic             out_fired_q;
  logic [15:0]      out_count_q;

  // Memories
  logic [31:0] due_mem [ALARM_SLOTS];
  logic [15:0] ft_mem  [ALARM_SLOTS];
  logic [31:0] due_rd_q;
  logic [15:0] ft_rd_q;
  logic        due_we;
  logic [31:0] due_wd;
  logic        ft_we;
  logic [15:0] ft_wd;
  logic [IDX_W-1:0] wr_addr;

  // Shared adder
  logic [31:0] alu_a, alu_b, alu_sum;
  logic        alu_sub;
  alu_flags_t  alu_flags;

  logic        in_beat;
  logic        out_load;
  logic [31:0] cur;
  logic [15:0] ft_cur;
  logic        fire_now;

  sat_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .flags_o (alu_flags)
  );

  assign in_stall_o = (state_q != SQ_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign cur        = running_q ? now_q : 32'd0;
  assign ft_cur     = ftv_q[rd_addr_q] ? ft_rd_q : 16'd0;
  assign out_load   = (state_q == SQ_EMIT) && (!out_valid_q || !out_stall_i);

  // Pick adder operands by step
  always_comb begin
    alu_a   = tv_q;
    alu_b   = now_q;
    alu_sub = 1'b0;
    case (state_q)
      SQ_SET_CMP: begin
        alu_a   = tv_q;
        alu_b   = cur;
        alu_sub = 1'b1;
      end
      SQ_SW_CHK: begin
        alu_a   = tv_q;
        alu_b   = due_rd_q;
        alu_sub = 1'b1;
      end
      SQ_EL_SUB: begin
        alu_a   = cur;
        alu_b   = last_q;
        alu_sub = 1'b1;
      end
      SQ_EL_ADD: begin
        alu_a = elapsed_q;
        alu_b = diff_q;
      end
      SQ_Q_CHK: begin
        alu_a   = cur;
        alu_b   = due_rd_q;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = tv_q;
        alu_b = now_q;
      end
    endcase
  end

  // Slot fires on query if armed, not fired and due by now
  assign fire_now = armed_q[idx_q] && !fired_q[idx_q] && alu_flags.carry;

  // Next state and step actions
  always_comb begin
    state_d       = state_q;
    running_d     = running_q;
    elapsed_d     = elapsed_q;
    last_d        = last_q;
    armed_d       = armed_q;
    fired_d       = fired_q;
    ftv_d         = ftv_q;
    k_d           = k_q;
    diff_d        = diff_q;
    gt_d          = gt_q;
    rd_addr_d     = rd_addr_q;
    res_status_d  = res_status_q;
    res_elapsed_d = res_elapsed_q;
    res_armed_d   = res_armed_q;
    res_fired_d   = res_fired_q;
    res_count_d   = res_count_q;
    due_we        = 1'b0;
    due_wd        = tv_q;
    ft_we         = 1'b0;
    ft_wd         = ft_cur + 16'd1;
    wr_addr       = idx_q;
    out_valid_d   = out_valid_q && out_stall_i;

    case (state_q)
      SQ_IDLE: begin
        if (in_beat) begin
          state_d       = SQ_DECODE;
          res_status_d  = ST_OK;
          res_elapsed_d = 32'd0;
          res_armed_d   = 1'b0;
          res_fired_d   = 1'b0;
          res_count_d   = 16'd0;
        end
      end
      SQ_DECODE: begin
        state_d = SQ_EMIT;
        case (op_q)
          OP_SET_TIME: state_d = SQ_SET_CMP;
          OP_READ_ELAP: begin
            if (!running_q) res_status_d = ST_NOT_RUNNING;
            else            state_d      = SQ_EL_SUB;
          end
          OP_ARM_ABS, OP_ARM_DELTA: begin
            if (!idx_ok_q) begin
              res_status_d = ST_BAD_INDEX;
            end else if (!running_q) begin
              res_status_d = ST_NOT_RUNNING;
            end else if (op_q == OP_ARM_DELTA && tv_q == 32'd0) begin
              res_status_d = ST_ZERO_DELTA;
            end else if (op_q == OP_ARM_ABS) begin
              due_we         = 1'b1;
              armed_d[idx_q] = 1'b1;
              fired_d[idx_q] = 1'b0;
            end else begin
              state_d = SQ_ARM_ADD;
            end
          end
          OP_QUERY: begin
            if (!idx_ok_q) begin
              res_status_d = ST_BAD_INDEX;
            end else begin
              rd_addr_d = idx_q;
              state_d   = SQ_Q_CHK;
            end
          end
          OP_CLEAR: begin
            if (!idx_ok_q) res_status_d   = ST_BAD_INDEX;
            else           fired_d[idx_q] = 1'b0;
          end
          default: state_d = SQ_EMIT;
        endcase
      end
      SQ_SET_CMP: begin
        if (alu_flags.zero) begin
          running_d = 1'b1;
          state_d   = SQ_EMIT;
        end else if (running_q && alu_flags.carry) begin
          state_d = SQ_SW_RD;
        end else begin
          state_d = SQ_EL_SUB;
        end
      end
      // Sweep: read one slot, then compare and fire
      SQ_SW_RD: begin
        rd_addr_d = k_q;
        state_d   = SQ_SW_CHK;
      end
      SQ_SW_CHK: begin
        if (armed_q[k_q] && alu_flags.carry) begin
          armed_d[k_q] = 1'b0;
          fired_d[k_q] = 1'b1;
          ftv_d[k_q]   = 1'b1;
          ft_we        = 1'b1;
          wr_addr      = k_q;
        end
        if (k_q == LAST_SLOT) begin
          k_d     = '0;
          state_d = SQ_EL_SUB;
        end else begin
          k_d     = k_q + IDX_W'(1);
          state_d = SQ_SW_RD;
        end
      end
      SQ_EL_SUB: begin
        diff_d  = alu_sum;
        gt_d    = alu_flags.carry && !alu_flags.zero;
        state_d = SQ_EL_ADD;
      end
      SQ_EL_ADD: begin
        if (gt_q) elapsed_d = alu_sum;
        if (op_q == OP_SET_TIME) begin
          last_d    = tv_q;
          running_d = 1'b1;
        end else begin
          last_d        = now_q;
          res_elapsed_d = gt_q ? alu_sum : elapsed_q;
        end
        state_d = SQ_EMIT;
      end
      SQ_ARM_ADD: begin
        due_we         = 1'b1;
        due_wd         = alu_sum;
        armed_d[idx_q] = 1'b1;
        fired_d[idx_q] = 1'b0;
        state_d        = SQ_EMIT;
      end
      SQ_Q_CHK: begin
        if (fire_now) begin
          armed_d[idx_q] = 1'b0;
          fired_d[idx_q] = 1'b1;
          ftv_d[idx_q]   = 1'b1;
          ft_we          = 1'b1;
        end
        res_armed_d = armed_q[idx_q] && !fire_now;
        res_fired_d = fired_q[idx_q] || fire_now;
        res_count_d = fire_now ? ft_cur + 16'd1 : ft_cur;
        state_d     = SQ_EMIT;
      end
      SQ_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      running_q   <= 1'b0;
      elapsed_q   <= 32'd0;
      last_q      <= 32'd0;
      armed_q     <= '0;
      fired_q     <= '0;
      ftv_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      elapsed_q   <= elapsed_d;
      last_q      <= last_d;
      armed_q     <= armed_d;
      fired_q     <= fired_d;
      ftv_q       <= ftv_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the request beat and work values
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_q     <= opcode_i;
      idx_q    <= alarm_index_i[IDX_W-1:0];
      idx_ok_q <= ({1'b0, alarm_index_i} < 9'(ALARM_SLOTS));
      tv_q     <= time_value_i;
      now_q    <= now_seconds_i;
    end
    diff_q        <= diff_d;
    gt_q          <= gt_d;
    rd_addr_q     <= rd_addr_d;
    res_status_q  <= res_status_d;
    res_elapsed_q <= res_elapsed_d;
    res_armed_q   <= res_armed_d;
    res_fired_q   <= res_fired_d;
    res_count_q   <= res_count_d;
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_elapsed_q <= res_elapsed_q;
      out_armed_q   <= res_armed_q;
      out_fired_q   <= res_fired_q;
      out_count_q   <= res_count_q;
    end
  end

  // Due and fire-count memories, registered read
  always_ff @(posedge clk_i) begin
    if (due_we) due_mem[wr_addr] <= due_wd;
    if (ft_we)  ft_mem[wr_addr]  <= ft_wd;
    due_rd_q <= due_mem[rd_addr_d];
    ft_rd_q  <= ft_mem[rd_addr_d];
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign elapsed_count_o   = out_elapsed_q;
  assign slot_armed_o      = out_armed_q;
  assign slot_fired_o      = out_fired_q;
  assign slot_fire_count_o = out_count_q;

  // A slot is never armed and fired at once
  a_armed_fired_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (armed_q & fired_q) == '0)
    else $error("slot armed and fired together");

  // Elapsed count moves only in the add step
  a_elapsed_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(elapsed_q) |-> $past(state_q == SQ_EL_ADD))
    else $error("elapsed count changed outside add step");

  // Sweep counter rests at zero while idle
  a_sweep_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SQ_IDLE) |-> (k_q == '0))
    else $error("sweep counter not reset");

  // Emitting a result shows a beat and frees the sequencer
  a_emit_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && state_q == SQ_IDLE))
    else $error("result not presented after emit");

endmodule

FILE: tb/alarm_scoreboard_pkg.sv
package alarm_scoreboard_pkg;

  import sat_pkg::*;

  // One result beat as seen on the output ports
  typedef struct packed {
    status_e     status;
    logic [31:0] elapsed;
    logic        armed;
    logic        fired;
    logic [15:0] fire_count;
  } alarm_reply_t;

  class alarm_scoreboard;

    int unsigned  slots;
    bit [31:0]    due_sec[];
    bit           slot_armed[];
    bit           slot_fired[];
    bit [15:0]    fire_total[];
    bit           running;
    bit [31:0]    elapsed_sec;
    bit [31:0]    last_seen_sec;
    alarm_reply_t pending_replies[$];
    int unsigned  mismatches;

    function new(int unsigned n_slots);
      slots         = n_slots;
      due_sec       = new[n_slots];
      slot_armed    = new[n_slots];
      slot_fired    = new[n_slots];
      fire_total    = new[n_slots];
      running       = 1'b0;
      elapsed_sec   = '0;
      last_seen_sec = '0;
      mismatches    = 0;
    endfunction

    function int unsigned pending();
      return pending_replies.size();
    endfunction

    // Fire one slot: flag it, disarm it, bump its wrapping count
    function void fire_slot(int unsigned k);
      slot_fired[k] = 1'b1;
      slot_armed[k] = 1'b0;
      fire_total[k] = fire_total[k] + 16'd1;
    endfunction

    // Add forward progress of the clock to the elapsed count
    function void add_progress(bit [31:0] sec);
      if (sec > last_seen_sec) begin
        elapsed_sec = elapsed_sec + (sec - last_seen_sec);
      end
    endfunction

    // Apply one accepted request beat and queue the reply it must produce
    function void note_request(bit [2:0] op, bit [7:0] idx, bit [31:0] tv, bit [31:0] now);
      alarm_reply_t reply;
      bit [31:0]    cur;
      bit           idx_ok;
      int unsigned  s;
      reply  = '0;
      cur    = running ? now : 32'd0;
      idx_ok = idx < slots;
      s      = idx_ok ? idx : 0;
      case (op)
        OP_SET_TIME: begin
          if (cur != tv) begin
            if (running && tv > cur) begin
              for (int unsigned k = 0; k < slots; k++) begin
                if (slot_armed[k] && due_sec[k] <= tv) begin
                  fire_slot(k);
                end
              end
            end
            add_progress(cur);
            last_seen_sec = tv;
          end
          running = 1'b1;
        end
        OP_READ_ELAP: begin
          if (!running) begin
            reply.status = ST_NOT_RUNNING;
          end else begin
            add_progress(now);
            last_seen_sec = now;
            reply.elapsed = elapsed_sec;
          end
        end
        OP_ARM_ABS, OP_ARM_DELTA: begin
          if (!idx_ok) begin
            reply.status = ST_BAD_INDEX;
          end else if (!running) begin
            reply.status = ST_NOT_RUNNING;
          end else if (op == OP_ARM_DELTA && tv == 32'd0) begin
            reply.status = ST_ZERO_DELTA;
          end else begin
            due_sec[s]    = (op == OP_ARM_ABS) ? tv : tv + now;
            slot_armed[s] = 1'b1;
            slot_fired[s] = 1'b0;
          end
        end
        OP_QUERY: begin
          if (!idx_ok) begin
            reply.status = ST_BAD_INDEX;
          end else begin
            // Lazy fire when the slot is due by the present second
            if (slot_armed[s] && !slot_fired[s] && due_sec[s] <= cur) begin
              fire_slot(s);
            end
            reply.armed      = slot_armed[s];
            reply.fired      = slot_fired[s];
            reply.fire_count = fire_total[s];
          end
        end
        OP_CLEAR: begin
          if (!idx_ok) begin
            reply.status = ST_BAD_INDEX;
          end else begin
            slot_fired[s] = 1'b0;
          end
        end
        default: begin
        end
      endcase
      pending_replies.push_back(reply);
    endfunction

    // Print one line per mismatch, up to the first 100; keep the log short on a badly broken block
    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100) begin
        $display("[%0t] mismatch: %s", $realtime, what);
      end
    endtask

    // Compare a result beat with the oldest outstanding reply
    task check_result(alarm_reply_t got);
      alarm_reply_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result beat with no request outstanding, status %0d",
                                  got.status));
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) begin
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      end
      if (got.elapsed !== want.elapsed) begin
        report_mismatch($sformatf("elapsed_count %0d, want %0d", got.elapsed, want.elapsed));
      end
      if (got.armed !== want.armed) begin
        report_mismatch($sformatf("slot_armed %b, want %b", got.armed, want.armed));
      end
      if (got.fired !== want.fired) begin
        report_mismatch($sformatf("slot_fired %b, want %b", got.fired, want.fired));
      end
      if (got.fire_count !== want.fire_count) begin
        report_mismatch($sformatf("slot_fire_count %0d, want %0d",
                                  got.fire_count, want.fire_count));
      end
    endtask

  endclass

endpackage

FILE: tb/tb_top.sv
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import sat_pkg::*;
  import alarm_scoreboard_pkg::*;

  localparam int unsigned SLOTS        = ALARM_SLOTS_DEF;
  localparam int unsigned N_RANDOM     = 950;
  localparam int unsigned N_CALM_TAIL  = 120;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 2 * SLOTS + 20;

  // Opcodes the block decodes as no-ops
  localparam bit [2:0] OP_SPARE_6 = 3'd6;
  localparam bit [2:0] OP_SPARE_7 = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  opcode;
  logic [7:0]  alarm_index;
  logic [31:0] time_value;
  logic [31:0] now_seconds;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [31:0] elapsed_count;
  logic        slot_armed;
  logic        slot_fired;
  logic [15:0] slot_fire_count;

  alarm_scoreboard sb;
  alarm_reply_t    seen_reply;
  bit              quiet_tail = 1'b0;
  int unsigned     cycle_count = 0;

  seconds_alarm_table #(
    .ALARM_SLOTS(SLOTS)
  ) u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .alarm_index_i    (alarm_index),
    .time_value_i     (time_value),
    .now_seconds_i    (now_seconds),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .elapsed_count_o  (elapsed_count),
    .slot_armed_o     (slot_armed),
    .slot_fired_o     (slot_fired),
    .slot_fire_count_o(slot_fire_count)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Observe accepted beats on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_request(opcode, alarm_index, time_value, now_seconds);
      end
      if (out_valid && !out_stall) begin
        seen_reply.status     = status_e'(status);
        seen_reply.elapsed    = elapsed_count;
        seen_reply.armed      = slot_armed;
        seen_reply.fired      = slot_fired;
        seen_reply.fire_count = slot_fire_count;
        sb.check_result(seen_reply);
      end
    end
  end

  // Stall the result channel in bursts, with calm stretches in between
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_tail && ((cycle_count / 600) % 3 != 0) && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Present one request beat and hold it until accepted
  task automatic send_request(input bit [2:0] op, input bit [7:0] idx,
                              input bit [31:0] tv, input bit [31:0] now);
    in_valid    <= 1'b1;
    opcode      <= op;
    alarm_index <= idx;
    time_value  <= tv;
    now_seconds <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and let the sender idle
  task automatic idle_sender(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off the sender until every outstanding reply has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Error ordering, wrap cases, firing on set time and lazy firing on query
  task automatic run_directed();
    // Clock not running yet
    send_request(OP_READ_ELAP, 8'd0, 32'd0, 32'd0);
    send_request(OP_ARM_ABS, 8'd0, 32'd5, 32'd0);
    send_request(OP_ARM_DELTA, 8'd200, 32'd0, 32'd0);
    send_request(OP_ARM_DELTA, 8'd1, 32'd0, 32'd0);
    send_request(OP_QUERY, 8'd0, 32'd0, 32'd123);
    send_request(OP_CLEAR, 8'(SLOTS), 32'd0, 32'd0);
    send_request(OP_SPARE_6, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_SPARE_7, 8'd3, 32'd9, 32'd9);
    // Start the clock at zero with an ignored index
    send_request(OP_SET_TIME, 8'hFF, 32'd0, 32'd77);
    send_request(OP_READ_ELAP, 8'd0, 32'd0, 32'd1000);
    send_request(OP_ARM_ABS, 8'd0, 32'd1010, 32'd1000);
    send_request(OP_ARM_ABS, 8'(SLOTS - 1), 32'hFFFF_FFFF, 32'd1000);
    send_request(OP_ARM_DELTA, 8'd2, 32'd0, 32'd1000);
    send_request(OP_ARM_DELTA, 8'd3, 32'd5, 32'd1000);
    // Move forward past slot 3 only
    send_request(OP_SET_TIME, 8'd0, 32'd1008, 32'd1000);
    send_request(OP_QUERY, 8'd3, 32'd0, 32'd1008);
    send_request(OP_CLEAR, 8'd3, 32'd0, 32'd1008);
    send_request(OP_QUERY, 8'd3, 32'd0, 32'd1008);
    send_request(OP_QUERY, 8'd0, 32'd0, 32'd1020);
    // Delta sum wraps past 2^32
    send_request(OP_ARM_DELTA, 8'd4, 32'h20, 32'hFFFF_FFF0);
    send_request(OP_QUERY, 8'd4, 32'd0, 32'hFFFF_FFF0);
    // Move backward, then let the elapsed count wrap
    send_request(OP_SET_TIME, 8'd0, 32'd500, 32'd1020);
    send_request(OP_READ_ELAP, 8'd0, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_READ_ELAP, 8'd0, 32'd0, 32'd0);
    send_request(OP_SET_TIME, 8'd0, 32'hFFFF_FFFF, 32'd0);
    send_request(OP_QUERY, 8'(SLOTS - 1), 32'd0, 32'hFFFF_FFFF);
  endtask

  // Mostly coherent time flow: arm, advance, query, with some noise mixed in
  task automatic run_random();
    int unsigned useful;
    int unsigned pick;
    bit [31:0]   wall_sec;
    bit [2:0]    op;
    bit [7:0]    idx;
    bit [31:0]   tv;
    bit [31:0]   now;
    useful   = 0;
    wall_sec = $urandom;
    while (useful < N_RANDOM) begin
      quiet_tail = (useful >= N_RANDOM - N_CALM_TAIL);
      wall_sec   = wall_sec + $urandom_range(0, 3);
      now        = wall_sec;
      pick       = $urandom_range(0, 19);
      if (pick == 0) begin
        now = $urandom;
      end else if (pick == 1) begin
        now = wall_sec - $urandom_range(1, 30);
      end
      if ($urandom_range(0, 9) == 0) begin
        idx = 8'($urandom_range(0, 255));
      end else begin
        idx = 8'($urandom_range(0, SLOTS - 1));
      end
      tv   = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        op   = OP_SET_TIME;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          tv = $urandom;
        end else if (pick == 1) begin
          tv = 32'hFFFF_FFF0 + $urandom_range(0, 8);
        end else if (pick < 4) begin
          tv = now;
        end else if (pick < 6) begin
          tv = now - $urandom_range(1, 20);
        end else begin
          tv = now + $urandom_range(1, 15);
        end
        wall_sec = tv;
      end else if (pick < 25) begin
        op = OP_READ_ELAP;
      end else if (pick < 45) begin
        op   = OP_ARM_ABS;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          tv = $urandom;
        end else if (pick == 1) begin
          tv = wall_sec - $urandom_range(1, 10);
        end else begin
          tv = wall_sec + $urandom_range(0, 12);
        end
      end else if (pick < 65) begin
        op   = OP_ARM_DELTA;
        pick = $urandom_range(0, 11);
        if (pick == 0) begin
          tv = 32'd0;
        end else if (pick != 1) begin
          tv = $urandom_range(1, 12);
        end
      end else if (pick < 85) begin
        op = OP_QUERY;
      end else if (pick < 97) begin
        op = OP_CLEAR;
      end else begin
        op = pick[0] ? OP_SPARE_6 : OP_SPARE_7;
      end
      send_request(op, idx, tv, now);
      if (op <= OP_CLEAR) begin
        useful++;
      end
      if (!quiet_tail && op <= OP_CLEAR && useful % 150 == 0) begin
        wait_for_results();
      end else if (!quiet_tail && ((useful / 80) % 3 != 0) && $urandom_range(0, 3) == 0) begin
        idle_sender($urandom_range(1, 14));
      end
    end
  endtask

  // Reset, stimulus, drain, verdict
  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    opcode      <= '0;
    alarm_index <= '0;
    time_value  <= '0;
    now_seconds <= '0;
    sb = new(SLOTS);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    run_directed();
    wait_for_results();
    run_random();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/sat_pkg.sv
hdl/sat_alu.sv
hdl/seconds_alarm_table.sv
tb/alarm_scoreboard_pkg.sv
tb/tb_top.sv
